// ===== rtl/core/tsasr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsasr_pkg
// Shared types, widths, register indexes and rotation codes for the touch
// sample averager.
// ----------------------------------------------------------------------------
package tsasr_pkg;

	localparam int RAW_W  = 12;   // raw conversion width
	localparam int DIM_W  = 10;   // screen dimension / coordinate width
	localparam int ROT_W  = 2;
	localparam int ACNT_W = 8;    // attempt counter
	localparam int VCNT_W = 5;    // valid sample counter
	localparam int SUM_W  = 16;   // sample sums, origin offset, divisor
	localparam int NUM_W  = DIM_W + SUM_W;   // dividend / quotient width
	localparam int STEP_W = 5;    // divider step counter, holds NUM_W
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int IN_W   = 24;   // two raw fields
	localparam int OUT_W  = 24;   // two coordinates, padded to bytes

	localparam int SAMPLES_DEF  = 10;
	localparam int ATTEMPTS_DEF = 20;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd6;

	// rotation codes
	localparam logic [ROT_W-1:0] ROT_PORTRAIT      = 2'd0;
	localparam logic [ROT_W-1:0] ROT_LANDSCAPE     = 2'd1;
	localparam logic [ROT_W-1:0] ROT_INV_PORTRAIT  = 2'd2;
	localparam logic [ROT_W-1:0] ROT_INV_LANDSCAPE = 2'd3;

	// register reset values
	localparam logic [RAW_W-1:0] X_MIN_RST  = 12'd100;
	localparam logic [RAW_W-1:0] X_MAX_RST  = 12'd1900;
	localparam logic [RAW_W-1:0] Y_MIN_RST  = 12'd200;
	localparam logic [RAW_W-1:0] Y_MAX_RST  = 12'd1950;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 10'd240;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 10'd320;

	// controller to datapath
	typedef struct packed {
		logic accept;      // input transaction this cycle
		logic prep;        // form origin offset and divisor
		logic mul;         // form dividend, arm divider
		logic div_step;    // one quotient bit
		logic axis_y;      // prep/mul work on Y, else X
		logic store_x;     // capture saturated X quotient
		logic load_out;    // fill output register, restart collection
		logic load_touch;  // output register gets a touched result
	} tsasr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic finish_touch; // this input completes a good average
		logic finish_zero;  // this input ends the run without a touch
		logic div_done;
		logic out_free;
	} tsasr_status_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_PREP_X = 8'b0000_0010,
		ST_MUL_X  = 8'b0000_0100,
		ST_DIV_X  = 8'b0000_1000,
		ST_PREP_Y = 8'b0001_0000,
		ST_MUL_Y  = 8'b0010_0000,
		ST_DIV_Y  = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} tsasr_state_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [NUM_W-1:0] q,
			input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] r;
		if (q > NUM_W'(dim)) begin
			r = dim;
		end else begin
			r = q[DIM_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/tsasr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsasr_ctrl
// Sequencer: takes samples, runs the X then Y scale divisions when a run
// closes with a touch, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tsasr_ctrl
	import tsasr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tsasr_status_t status,
	output tsasr_cmd_t    cmd
);

	tsasr_state_t state_q, state_d;
	logic         touch_q, touch_d;
	logic         acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		touch_d = touch_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = acc;
				if (acc && status.finish_touch) begin
					state_d = ST_PREP_X;
					touch_d = 1'b1;
				end else if (acc && status.finish_zero) begin
					state_d = ST_OUT;
					touch_d = 1'b0;
				end
			end
			ST_PREP_X: begin
				cmd.prep = 1'b1;
				state_d  = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV_X;
			end
			ST_DIV_X: begin
				if (status.div_done) begin
					state_d = ST_PREP_Y;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_PREP_Y: begin
				cmd.prep    = 1'b1;
				cmd.axis_y  = 1'b1;
				cmd.store_x = 1'b1;
				state_d     = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul    = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (status.div_done) begin
					state_d = ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_OUT: begin
				// hold until the output register is free
				cmd.load_touch = touch_q;
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			touch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			touch_q <= touch_d;
		end
	end

endmodule

// ===== rtl/core/tsasr_dp.sv =====
// ----------------------------------------------------------------------------
// tsasr_dp
// Datapath: configuration registers, sample accumulators, shared restoring
// divider, rotation and output register.
// ----------------------------------------------------------------------------
module tsasr_dp
	import tsasr_pkg::*;
#(
	parameter int SAMPLES  = SAMPLES_DEF,
	parameter int ATTEMPTS = ATTEMPTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [RAW_W-1:0]      x_raw,
	input  logic [RAW_W-1:0]      y_raw,
	input  tsasr_cmd_t            cmd,
	output tsasr_status_t         status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DIM_W-1:0]      pos_x,
	output logic [DIM_W-1:0]      pos_y,
	output logic                  touched
);

	// configuration
	logic [ROT_W-1:0] rotation_q;
	logic [RAW_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [DIM_W-1:0] width_q, height_q;

	// collection state
	logic [ACNT_W-1:0] attempt_q, attempt_nx;
	logic [VCNT_W-1:0] valid_q, valid_nx;
	logic [SUM_W-1:0]  sum_x_q, sum_y_q;
	logic              sample_ok, ranges_ok, enough;

	// divider
	logic [SUM_W-1:0]  diff_q, den_q;
	logic [NUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W:0]    shifted;
	logic [DIM_W-1:0]  px_q;

	// axis selection
	logic [SUM_W-1:0] sel_sum, base;
	logic [RAW_W-1:0] sel_lo, sel_hi;
	logic [DIM_W-1:0] sel_dim;

	// output
	logic             out_valid_q, touched_q;
	logic [DIM_W-1:0] pos_x_q, pos_y_q, py, ox, oy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_PORTRAIT;
			x_min_q    <= X_MIN_RST;
			x_max_q    <= X_MAX_RST;
			y_min_q    <= Y_MIN_RST;
			y_max_q    <= Y_MAX_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROTATION: rotation_q <= cfg_data[ROT_W-1:0];
				CFG_X_MIN:    x_min_q    <= cfg_data[RAW_W-1:0];
				CFG_X_MAX:    x_max_q    <= cfg_data[RAW_W-1:0];
				CFG_Y_MIN:    y_min_q    <= cfg_data[RAW_W-1:0];
				CFG_Y_MAX:    y_max_q    <= cfg_data[RAW_W-1:0];
				CFG_WIDTH:    width_q    <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// completion decision for the sample on the input
	assign sample_ok = (x_raw >= x_min_q) && (x_raw <= x_max_q) &&
		(y_raw >= y_min_q) && (y_raw <= y_max_q);
	assign attempt_nx = attempt_q + ACNT_W'(1);
	assign valid_nx   = valid_q + VCNT_W'(sample_ok);
	assign enough     = (valid_nx >= VCNT_W'(SAMPLES));
	assign ranges_ok  = (x_max_q > x_min_q) && (y_max_q > y_min_q);

	assign status.finish_touch = enough && ranges_ok;
	assign status.finish_zero  = (enough && !ranges_ok) ||
		(!enough && (attempt_nx >= ACNT_W'(ATTEMPTS)));
	assign status.div_done = (step_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_q <= '0;
			valid_q   <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
		end else if (cmd.load_out) begin
			attempt_q <= '0;
			valid_q   <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
		end else if (cmd.accept) begin
			attempt_q <= attempt_nx;
			valid_q   <= valid_nx;
			if (sample_ok) begin
				sum_x_q <= sum_x_q + SUM_W'(x_raw);
				sum_y_q <= sum_y_q + SUM_W'(y_raw);
			end
		end
	end

	assign sel_sum = cmd.axis_y ? sum_y_q  : sum_x_q;
	assign sel_lo  = cmd.axis_y ? y_min_q  : x_min_q;
	assign sel_hi  = cmd.axis_y ? y_max_q  : x_max_q;
	assign sel_dim = cmd.axis_y ? height_q : width_q;
	assign base    = SUM_W'(SAMPLES) * SUM_W'(sel_lo);

	assign shifted = {rem_q, num_q[NUM_W-1]};

	// offset and divisor, then dividend, then one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			diff_q <= (sel_sum > base) ? (sel_sum - base) : '0;
			den_q  <= SUM_W'(SAMPLES) * SUM_W'(sel_hi - sel_lo);
		end
		if (cmd.mul) begin
			num_q <= NUM_W'(sel_dim) * NUM_W'(diff_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= SUM_W'(shifted - {1'b0, den_q});
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SUM_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.store_x) begin
			px_q <= sat_dim(num_q, width_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.mul) begin
			step_q <= STEP_W'(NUM_W);
		end else if (cmd.div_step) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	// Y quotient is still in the divider when the result is formed
	assign py = sat_dim(num_q, height_q);

	always_comb begin
		case (rotation_q)
			ROT_PORTRAIT: begin
				ox = px_q;
				oy = height_q - py;
			end
			ROT_LANDSCAPE: begin
				ox = height_q - py;
				oy = width_q - px_q;
			end
			ROT_INV_PORTRAIT: begin
				ox = width_q - px_q;
				oy = py;
			end
			default: begin
				ox = py;
				oy = px_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			touched_q <= cmd.load_touch;
			pos_x_q   <= cmd.load_touch ? ox : '0;
			pos_y_q   <= cmd.load_touch ? oy : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign touched   = touched_q;

`ifndef ASSERT_OFF
	// a full run must never take a further sample before it is restarted
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q >= VCNT_W'(SAMPLES)) |-> !cmd.accept)
		else $error("sample accepted after the run was complete");

	// never overwrite a result that is still waiting
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while occupied");

	// restoring divider keeps its partial remainder below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < den_q))
		else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/core/touch_sample_average_scale_rotate.sv =====
// ----------------------------------------------------------------------------
// touch_sample_average_scale_rotate
// Averages raw touch conversion pairs, scales them to screen pixels and
// applies one of four panel rotations.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Contents
// s_*      in         raw pair: x_raw [11:0], y_raw [23:12]
// m_*      out        result: pos_x [9:0], pos_y [19:10]; tuser = touched
// cfg_*    in         register write: index 0..6, data [11:0]
//
// A sample that does not close a run is taken back to back.
// A sample that closes a run with a touch runs two 26-step restoring
// divisions (one quotient bit per cycle, shared by X and Y) plus offset
// and multiply steps; a run that ends without a touch goes straight to
// the output register.
// Reset clears counters, sums and the output valid; registers take their
// defaults. A waiting result stalls only the next closing sample.
//
module touch_sample_average_scale_rotate
	import tsasr_pkg::*;
#(
	parameter int SAMPLES  = SAMPLES_DEF,   // valid pairs per average, 1..16
	parameter int ATTEMPTS = ATTEMPTS_DEF   // pairs allowed per run, 1..255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// raw sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // x_raw [11:0], y_raw [23:12]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // pos_x [9:0], pos_y [19:10], zero pad
	output logic                  m_tuser,   // touched
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tsasr_cmd_t       cmd;
	tsasr_status_t    status;
	logic [DIM_W-1:0] pos_x, pos_y;

	// sequencer: one transaction in, divisions, then the result register
	tsasr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// accumulators, divider, rotation and output register
	tsasr_dp #(
		.SAMPLES  (SAMPLES),
		.ATTEMPTS (ATTEMPTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.x_raw     (s_tdata[RAW_W-1:0]),
		.y_raw     (s_tdata[2*RAW_W-1:RAW_W]),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.touched   (m_tuser)
	);

	// pack coordinates, pad the upper bits
	assign m_tdata = {(OUT_W - 2*DIM_W)'(0), pos_y, pos_x};

endmodule
